### rtl/spsl_pkg.sv
package spsl_pkg;

   localparam int DEFAULT_NUM_CHANNELS = 6;
   localparam int MAX_CHANNELS         = 8;
   localparam int OFFSET_CHANNELS      = 6;
   localparam int FLAG_WIDTH           = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [15:0] NEUTRAL_RESET = 16'd30000;
   localparam logic [7:0]  GAIN_RESET    = 8'd142;
   localparam logic [14:0] SLEW_RESET    = 15'd724;

   // The step is floor(gain * speed / 50). The product is halved first and then
   // divided by 25 through a reciprocal multiplication that is exact for every
   // halved product below 2**15.
   localparam int SPEED_DIVISOR = 50;
   localparam int HALF_DIVISOR  = SPEED_DIVISOR / 2;
   localparam int RECIP_SHIFT   = 20;
   localparam int RECIP_FACTOR  = (2 ** RECIP_SHIFT + HALF_DIVISOR - 1) / HALF_DIVISOR;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NEUTRAL_COUNT  = 3'd0,
      CSR_GAIN_PER_UNIT  = 3'd1,
      CSR_MAX_SLEW       = 3'd2,
      CSR_DIRECTION_MASK = 3'd3,
      CSR_OFFSET_TABLE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] next_compare;
      logic        locked;
   } slew_result_type;

endpackage

### rtl/spsl_slew.sv
module spsl_slew (
   input  logic [15:0]              wanted,
   input  logic [14:0]              step,
   input  logic [15:0]              current,
   output spsl_pkg::slew_result_type result
);
   import spsl_pkg::*;

   logic [15:0]        diff_u;
   logic signed [16:0] diff_s;
   logic signed [16:0] step_s;

   // The distance is read as a signed 16-bit value so the compare moves the short way round.
   assign diff_u = wanted - current;
   assign diff_s = signed'({diff_u[15], diff_u});
   assign step_s = signed'({2'b00, step});

   always_comb begin
      if (diff_s > step_s) begin
         result.next_compare = current + {1'b0, step};
         result.locked       = 1'b0;
      end else if (diff_s < -step_s) begin
         result.next_compare = current - {1'b0, step};
         result.locked       = 1'b0;
      end else begin
         result.next_compare = wanted;
         result.locked       = 1'b1;
      end
   end

endmodule

### rtl/servo_pulse_slew_limiter_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: channel, target_position, speed_setting
// rsp_      out        rsp_tvalid/rsp_tready  tdata: compare_value, locked, lock_flags
// csr_      in         csr_we                 csr_addr, csr_wdata
//
// One beat is accepted in every cycle while no stage stalls; each request passes the a, b and
// c stage registers before its result is registered in the output register.
// The channel's stored compare value is read and rewritten in the last stage, so
// consecutive beats for the same channel see each other's updates.
// Reset clears the stages, loads the register defaults and sets every channel to 30000.
// A stalled result holds its stage; earlier stages keep filling any empty slots.
module servo_pulse_slew_limiter_core #(
   parameter int NUM_CHANNELS = spsl_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // channel [2:0], target_position [10:3], speed_setting [18:11], zero [23:19]
   input  logic [23:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // compare_value [15:0], locked [16], lock_flags [22:17], zero [23]
   output logic [23:0]                      rsp_tdata,
   input  logic                             csr_we,
   input  logic [spsl_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [spsl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import spsl_pkg::*;

   logic [15:0] neutral_ff;
   logic [7:0]  gain_ff;
   logic [14:0] slew_ff;
   logic [5:0]  direction_ff;
   logic [47:0] offset_ff;

   logic        a_valid_ff;
   logic [2:0]  a_channel_ff;
   logic [7:0]  a_position_ff;
   logic [7:0]  a_speed_ff;

   logic        b_valid_ff;
   logic [2:0]  b_channel_ff;
   logic [15:0] b_term_ff;
   logic        b_invert_ff;
   logic [15:0] b_product_ff;

   logic        c_valid_ff;
   logic [2:0]  c_channel_ff;
   logic [15:0] c_wanted_ff;
   logic [14:0] c_step_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_compare_ff;
   logic        rsp_locked_ff;
   logic [5:0]  rsp_flags_ff;

   logic [15:0]             compare_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] lock_ff;
   logic [NUM_CHANNELS-1:0] lock_in;

   logic out_ok;
   logic c_ok;
   logic b_ok;
   logic a_ok;

   logic [7:0]         offset_sel;
   logic               invert_sel;
   logic signed [8:0]  sum_s;
   logic signed [17:0] term_full;
   logic [15:0]        term_in;
   logic [15:0]        product_in;
   logic [15:0]        wanted_in;
   logic [30:0]        recip_product;
   logic [10:0]        quotient;
   logic [14:0]        step_in;
   logic [15:0]        current_sel;
   logic               in_range;
   slew_result_type    slew;
   logic [MAX_CHANNELS-1:0] lock_pad;

   assign out_ok     = !rsp_valid_ff || rsp_tready;
   assign c_ok       = !c_valid_ff || out_ok;
   assign b_ok       = !b_valid_ff || c_ok;
   assign a_ok       = !a_valid_ff || b_ok;
   assign req_tready = a_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff   <= NEUTRAL_RESET;
         gain_ff      <= GAIN_RESET;
         slew_ff      <= SLEW_RESET;
         direction_ff <= '0;
         offset_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NEUTRAL_COUNT:  neutral_ff   <= csr_wdata[15:0];
            CSR_GAIN_PER_UNIT:  gain_ff      <= csr_wdata[7:0];
            CSR_MAX_SLEW:       slew_ff      <= csr_wdata[14:0];
            CSR_DIRECTION_MASK: direction_ff <= csr_wdata[5:0];
            CSR_OFFSET_TABLE:   offset_ff    <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      offset_sel = '0;
      invert_sel = 1'b0;
      for (int i = 0; i < OFFSET_CHANNELS; i++) begin
         if (a_channel_ff == 3'(i)) begin
            offset_sel = offset_ff[8*i +: 8];
            invert_sel = direction_ff[i];
         end
      end
   end

   assign sum_s      = signed'({offset_sel[7], offset_sel})
                     + signed'({a_position_ff[7], a_position_ff});
   assign term_full  = signed'({1'b0, gain_ff}) * sum_s;
   assign term_in    = term_full[15:0];
   assign product_in = gain_ff * a_speed_ff;

   assign wanted_in     = neutral_ff + (b_invert_ff ? -b_term_ff : b_term_ff);
   assign recip_product = 31'(b_product_ff[15:1]) * 31'(RECIP_FACTOR);
   assign quotient      = recip_product[RECIP_SHIFT +: 11];
   assign step_in       = ({4'b0000, quotient} > slew_ff) ? slew_ff : {4'b0000, quotient};

   always_comb begin
      current_sel = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (c_channel_ff == 3'(i)) begin
            current_sel = compare_ff[i];
         end
      end
   end

   assign in_range = {1'b0, c_channel_ff} < 4'(NUM_CHANNELS);

   spsl_slew u_slew (
      .wanted  (c_wanted_ff),
      .step    (c_step_ff),
      .current (current_sel),
      .result  (slew)
   );

   always_comb begin
      lock_in = lock_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (c_channel_ff == 3'(i)) begin
            lock_in[i] = slew.locked;
         end
      end
   end

   assign lock_pad = MAX_CHANNELS'(lock_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lock_ff      <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            compare_ff[i] <= NEUTRAL_RESET;
         end
      end else begin
         if (a_ok) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_ok) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ok) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_ok) begin
            rsp_valid_ff <= c_valid_ff;
            if (c_valid_ff && in_range) begin
               lock_ff <= lock_in;
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (c_channel_ff == 3'(i)) begin
                     compare_ff[i] <= slew.next_compare;
                  end
               end
            end
         end
      end
   end

   // An out-of-range channel matches no lock bit, so the flags then show the held bits.
   always_ff @(posedge clock) begin
      if (a_ok) begin
         a_channel_ff  <= req_tdata[2:0];
         a_position_ff <= req_tdata[10:3];
         a_speed_ff    <= req_tdata[18:11];
      end
      if (b_ok) begin
         b_channel_ff <= a_channel_ff;
         b_term_ff    <= term_in;
         b_invert_ff  <= invert_sel;
         b_product_ff <= product_in;
      end
      if (c_ok) begin
         c_channel_ff <= b_channel_ff;
         c_wanted_ff  <= wanted_in;
         c_step_ff    <= step_in;
      end
      if (out_ok) begin
         rsp_flags_ff <= lock_pad[FLAG_WIDTH-1:0];
         if (in_range) begin
            rsp_compare_ff <= slew.next_compare;
            rsp_locked_ff  <= slew.locked;
         end else begin
            rsp_compare_ff <= '0;
            rsp_locked_ff  <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_flags_ff, rsp_locked_ff, rsp_compare_ff};

endmodule

### rtl/spsl_checker.sv
module spsl_checker #(
   parameter int NUM_CHANNELS = spsl_pkg::DEFAULT_NUM_CHANNELS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [23:0]                      rsp_tdata
);
   import spsl_pkg::*;

   // After reset the pipeline is empty and ready for a beat.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   // A locked result always shows a nonzero lock flag field when every channel is visible.
   a_lock_flag: assert property (@(posedge clock) disable iff (reset)
      (NUM_CHANNELS <= FLAG_WIDTH && rsp_tvalid && rsp_tdata[16]) |-> (rsp_tdata[22:17] != 6'd0))
      else $error("locked result without a lock flag");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[23])
      else $error("result padding bit set");

endmodule

bind servo_pulse_slew_limiter_core spsl_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_spsl_checker (.*);

### bench/servo_pulse_slew_limiter_core_tb.sv
typedef struct packed {
   logic [5:0]  lock_flags;
   logic        locked;
   logic [15:0] compare_value;
} servo_update_type;

class servo_update_tracker;
   localparam int SERVOS = spsl_pkg::DEFAULT_NUM_CHANNELS;

   logic [15:0]      neutral;
   logic [7:0]       gain;
   logic [14:0]      slew_limit;
   logic [5:0]       invert_mask;
   logic [47:0]      trim_table;
   logic [15:0]      channel_compare [spsl_pkg::MAX_CHANNELS];
   logic [7:0]       lock_state;
   servo_update_type pending_updates [$];
   int               errors;

   function new();
      neutral     = spsl_pkg::NEUTRAL_RESET;
      gain        = spsl_pkg::GAIN_RESET;
      slew_limit  = spsl_pkg::SLEW_RESET;
      invert_mask = '0;
      trim_table  = '0;
      for (int i = 0; i < spsl_pkg::MAX_CHANNELS; i++) begin
         channel_compare[i] = spsl_pkg::NEUTRAL_RESET;
      end
      lock_state = '0;
      errors     = 0;
   endfunction

   function void set_reg(spsl_pkg::csr_index_type idx, logic [47:0] value);
      case (idx)
         spsl_pkg::CSR_NEUTRAL_COUNT:  neutral     = value[15:0];
         spsl_pkg::CSR_GAIN_PER_UNIT:  gain        = value[7:0];
         spsl_pkg::CSR_MAX_SLEW:       slew_limit  = value[14:0];
         spsl_pkg::CSR_DIRECTION_MASK: invert_mask = value[5:0];
         spsl_pkg::CSR_OFFSET_TABLE:   trim_table  = value;
         default: ;
      endcase
   endfunction

   function int pending();
      return pending_updates.size();
   endfunction

   // Works out the channel's new compare value for one accepted request beat.
   function void predict_update(logic [23:0] beat);
      logic [2:0]        ch;
      logic signed [7:0] pos;
      logic [7:0]        spd;
      int                trim;
      int                term;
      int                step;
      int                delta;
      logic [15:0]       wanted;
      logic [15:0]       cur;
      logic [15:0]       gap;
      logic [15:0]       next;
      logic              lock;
      servo_update_type  upd;
      ch  = beat[2:0];
      pos = beat[10:3];
      spd = beat[18:11];
      if (ch >= SERVOS) begin
         upd.compare_value = '0;
         upd.locked        = 1'b0;
         upd.lock_flags    = lock_state[5:0];
         pending_updates.push_back(upd);
         return;
      end
      trim = 0;
      term = 0;
      if (ch < spsl_pkg::OFFSET_CHANNELS) begin
         trim = $signed(trim_table[8*ch +: 8]);
      end
      term = int'(gain) * (trim + int'(pos));
      if (ch < spsl_pkg::OFFSET_CHANNELS && invert_mask[ch]) begin
         term = -term;
      end
      wanted = 16'(int'(neutral) + term);
      step   = int'(gain) * int'(spd) / spsl_pkg::SPEED_DIVISOR;
      if (step > int'(slew_limit)) begin
         step = int'(slew_limit);
      end
      cur   = channel_compare[ch];
      gap   = wanted - cur;
      delta = $signed(gap);
      if (delta > step) begin
         next = cur + 16'(step);
         lock = 1'b0;
      end else if (delta < -step) begin
         next = cur - 16'(step);
         lock = 1'b0;
      end else begin
         next = wanted;
         lock = 1'b1;
      end
      channel_compare[ch] = next;
      lock_state[ch]      = lock;
      upd.compare_value   = next;
      upd.locked          = lock;
      upd.lock_flags      = lock_state[5:0];
      pending_updates.push_back(upd);
   endfunction

   task report(string field, int got, int want);
      errors++;
      if (errors <= 50) begin
         $display("mismatch in %s: got %0d, expected %0d", field, got, want);
      end
   endtask

   task check_update(logic [23:0] beat);
      servo_update_type want;
      if (pending_updates.size() == 0) begin
         report("unexpected result beat", beat, 0);
         return;
      end
      want = pending_updates.pop_front();
      if (beat[15:0] != want.compare_value) begin
         report("compare_value", beat[15:0], want.compare_value);
      end
      if (beat[16] != want.locked) begin
         report("locked", beat[16], want.locked);
      end
      if (beat[22:17] != want.lock_flags) begin
         report("lock_flags", beat[22:17], want.lock_flags);
      end
   endtask
endclass

module servo_pulse_slew_limiter_core_tb;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASES       = 10;
   localparam int PHASE_BEATS  = 130;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [23:0]                     req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [23:0]                     rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [spsl_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [spsl_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int                  cycles = 0;
   int                  tx_idle_pct = 0;
   int                  rx_idle_pct = 0;
   servo_update_tracker tracker = new();

   servo_pulse_slew_limiter_core #(
      .NUM_CHANNELS(spsl_pkg::DEFAULT_NUM_CHANNELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   // Results are checked before requests are noted, so a beat never meets its own prediction.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_update(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            tracker.predict_update(req_tdata);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(input logic [2:0] ch, input logic [7:0] pos, input logic [7:0] spd);
      int gap;
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, spd, pos, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input spsl_pkg::csr_index_type idx, input logic [47:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] neutral, input logic [7:0] gain,
                                input logic [14:0] slew, input logic [5:0] mask,
                                input logic [47:0] trims);
      drain_results();
      write_reg(spsl_pkg::CSR_NEUTRAL_COUNT, 48'(neutral));
      write_reg(spsl_pkg::CSR_GAIN_PER_UNIT, 48'(gain));
      write_reg(spsl_pkg::CSR_MAX_SLEW, 48'(slew));
      write_reg(spsl_pkg::CSR_DIRECTION_MASK, 48'(mask));
      write_reg(spsl_pkg::CSR_OFFSET_TABLE, trims);
   endtask

   // Mostly runs of one channel chasing a fixed target, so that channels reach lock.
   task automatic random_beats(input int count);
      int         sent;
      int         runs;
      int         hold_at;
      logic [2:0] ch;
      logic [7:0] pos;
      logic [7:0] spd;
      sent    = 0;
      hold_at = $urandom_range(10, count - 10);
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            ch   = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            pos  = 8'($urandom);
            spd  = 8'($urandom);
            runs = $urandom_range(2, 12);
            repeat (runs) begin
               if ($urandom_range(0, 7) == 0) begin
                  spd = 8'($urandom);
               end
               send(ch, pos, spd);
               sent++;
            end
         end else begin
            send(3'($urandom), 8'($urandom), 8'($urandom));
            sent++;
         end
         if (hold_at >= 0 && sent >= hold_at) begin
            hold_at = -1;
            drain_results();
         end
      end
   endtask

   initial begin
      logic [63:0] r;
      logic [47:0] trims;
      logic [14:0] slew;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(3'd0, 8'h00, 8'h00);
      send(3'd1, 8'h7F, 8'hFF);
      send(3'd1, 8'h7F, 8'hFF);
      send(3'd2, 8'h80, 8'h01);
      send(3'd2, 8'h80, 8'h00);
      send(3'd6, 8'h55, 8'hFF);
      send(3'd7, 8'hAA, 8'h00);
      send(3'd5, 8'h7F, 8'hFF);
      send(3'd5, 8'h7F, 8'hFF);

      load_settings(16'd65000, 8'd255, 15'h7FFF, 6'b000010, 48'h0000_0000_7F00);
      send(3'd3, 8'h00, 8'hFF);
      send(3'd0, 8'h7F, 8'hFF);
      send(3'd1, 8'h7F, 8'hFF);
      send(3'd4, 8'h80, 8'hFF);
      send(3'd5, 8'h01, 8'h00);
      send(3'd7, 8'hFF, 8'hFF);

      load_settings(16'd0, 8'd0, 15'd0, 6'd0, 48'd0);
      send(3'd0, 8'h00, 8'h00);
      send(3'd0, 8'hFF, 8'hFF);

      for (int p = 0; p < PHASES; p++) begin
         r     = {$urandom, $urandom};
         trims = r[47:0];
         slew  = ($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 2000)) : 15'($urandom);
         case (p)
            0: load_settings(16'hFFFF, 8'hFF, 15'h7FFF, 6'h3F, 48'hFFFF_FFFF_FFFF);
            1: load_settings(16'd0, 8'd0, 15'd0, 6'd0, 48'd0);
            2: load_settings(16'($urandom), 8'd255, slew, 6'($urandom), 48'h8080_8080_8080);
            3: load_settings(16'($urandom), 8'($urandom), slew, 6'($urandom),
                             48'h7F7F_7F7F_7F7F);
            default: load_settings(16'($urandom), 8'($urandom), slew, 6'($urandom), trims);
         endcase
         if (p == PHASES - 1) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else begin
            tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 8 * $urandom_range(1, 4);
            rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 8 * $urandom_range(1, 4);
         end
         random_beats(PHASE_BEATS);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
